// File: sv/bsps_pkg.sv
package bsps_pkg;

    localparam int MAX_STREAMS = 16;
    localparam int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
    localparam int ID_W        = 16;
    localparam int RATE_W      = 31;
    localparam int PREFIX_W    = 32;

    localparam logic [PREFIX_W-1:0] AUDIO_PREFIX = 32'hf8699e40;
    localparam logic [PREFIX_W-1:0] VIDEO_PREFIX = 32'hbc19efc0;

    // Command codes
    localparam logic [1:0] MODE_DECL   = 2'd0;
    localparam logic [1:0] MODE_RATE   = 2'd1;
    localparam logic [1:0] MODE_SELECT = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [PREFIX_W-1:0] type_prefix;
        logic [ID_W-1:0]     stream_num;
        logic [RATE_W-1:0]   rate;
    } cmd_t;

    typedef struct packed {
        logic            audio_found;
        logic [ID_W-1:0] audio_choice;
        logic            video_found;
        logic [ID_W-1:0] video_choice;
        logic            none_fit;
        logic            table_overflow;
    } result_t;

    // One table entry as stored in the stream RAM
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [RATE_W-1:0] rate;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Access request from the sequencer to one table RAM
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

// File: sv/bandwidth_stream_pair_selector.sv
// Stream pair selector. A declaration (mode 0) is written as it is taken and
// the next command may follow at once. A bitrate record (mode 1) walks both
// stream tables in parallel and holds busy until both walks are through. A
// select (mode 2) makes three walks over the table RAMs (lowest audio rate,
// best video, best audio) and holds busy until the last walk is through.
// Done is then driven for exactly one cycle with the result beat, in the
// first cycle with busy low; the receiver cannot stall, so the beat must be
// captured in that cycle. Each table RAM has a single registered read port,
// which visits one entry per cycle. The budget register must be written only
// while busy is low and no command is being issued; the block itself does
// not enforce this.
module bandwidth_stream_pair_selector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bsps_pkg::cmd_t              cmd,
    output logic                        done,
    output bsps_pkg::result_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bsps_pkg::RATE_W-1:0] cfg_data
);

    import bsps_pkg::*;

    logic [RATE_W-1:0] bandwidth_reg;
    mem_req_t          a_req;
    mem_req_t          v_req;
    logic [ENTRY_W-1:0] a_rdata;
    logic [ENTRY_W-1:0] v_rdata;

    assign cfg_ready = 1'b1;

    // Hold the bandwidth budget
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bandwidth_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bandwidth_reg <= cfg_data;
        end
    end

    bsps_ram #(
        .DEPTH (MAX_STREAMS),
        .WIDTH (ENTRY_W)
    ) u_audio_ram (
        .clk   (clk),
        .we    (a_req.we),
        .waddr (a_req.waddr),
        .wdata (a_req.wdata),
        .raddr (a_req.raddr),
        .rdata (a_rdata)
    );

    bsps_ram #(
        .DEPTH (MAX_STREAMS),
        .WIDTH (ENTRY_W)
    ) u_video_ram (
        .clk   (clk),
        .we    (v_req.we),
        .waddr (v_req.waddr),
        .wdata (v_req.wdata),
        .raddr (v_req.raddr),
        .rdata (v_rdata)
    );

    bsps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .bandwidth (bandwidth_reg),
        .a_req     (a_req),
        .a_rdata   (a_rdata),
        .v_req     (v_req),
        .v_rdata   (v_rdata),
        .done      (done),
        .result    (result)
    );

endmodule

// File: sv/bsps_ram.sv
module bsps_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/bsps_ctrl.sv
module bsps_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bsps_pkg::cmd_t              cmd,
    input  logic [bsps_pkg::RATE_W-1:0] bandwidth,
    output bsps_pkg::mem_req_t          a_req,
    input  bsps_pkg::entry_t            a_rdata,
    output bsps_pkg::mem_req_t          v_req,
    input  bsps_pkg::entry_t            v_rdata,
    output logic                        done,
    output bsps_pkg::result_t           result
);

    import bsps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC,
        ST_AMIN,
        ST_VID,
        ST_AUD
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  acnt_reg, acnt_next;
    logic [CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              a_chk_reg, a_chk_next;
    logic              v_chk_reg, v_chk_next;
    logic              a_hit_reg, a_hit_next;
    logic              v_hit_reg, v_hit_next;
    logic [ID_W-1:0]   rec_id_reg, rec_id_next;
    logic [RATE_W-1:0] rec_rate_reg, rec_rate_next;
    logic [RATE_W-1:0] amin_reg, amin_next;
    logic              b1_found_reg, b1_found_next;
    logic [RATE_W-1:0] b1_rate_reg, b1_rate_next;
    logic [ID_W-1:0]   b1_id_reg, b1_id_next;
    logic              b2_found_reg, b2_found_next;
    logic [RATE_W-1:0] b2_rate_reg, b2_rate_next;
    logic [ID_W-1:0]   b2_id_reg, b2_id_next;
    logic              ba_found_reg, ba_found_next;
    logic [RATE_W-1:0] ba_rate_reg, ba_rate_next;
    logic [ID_W-1:0]   ba_id_reg, ba_id_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic              a_scan, v_scan;
    logic              a_issue, v_issue;
    logic              scan_done;
    logic [RATE_W-1:0] bw;
    logic [RATE_W-1:0] v_rate;
    logic              v_found;
    logic [ID_W-1:0]   v_id;
    logic [RATE_W:0]   vid_sum;
    logic [RATE_W:0]   aud_sum;
    logic              fits1, fits2, fits_a;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // Zero budget stands for the full range
    assign bw = (bandwidth == '0) ? '1 : bandwidth;

    // Video pick: fit with the lowest audio rate, else with audio dropped
    assign v_found = b1_found_reg || b2_found_reg;
    assign v_rate  = b1_found_reg ? b1_rate_reg : b2_rate_reg;
    assign v_id    = b1_found_reg ? b1_id_reg : b2_id_reg;

    // Fit tests, widened by one bit so the sum cannot wrap
    assign vid_sum = {1'b0, v_rdata.rate} + {1'b0, amin_reg};
    assign aud_sum = {1'b0, a_rdata.rate} + {1'b0, v_rate};
    assign fits1   = vid_sum <= {1'b0, bw};
    assign fits2   = v_rdata.rate <= bw;
    assign fits_a  = aud_sum <= {1'b0, bw};

    // Table walk: one entry read per cycle, checked in the cycle after its read
    assign a_scan    = (state_reg == ST_REC) || (state_reg == ST_AMIN) ||
                       (state_reg == ST_AUD);
    assign v_scan    = (state_reg == ST_REC) || (state_reg == ST_VID);
    assign a_issue   = a_scan && (idx_reg < acnt_reg);
    assign v_issue   = v_scan && (idx_reg < vcnt_reg);
    assign scan_done = !a_issue && !v_issue && !a_chk_reg && !v_chk_reg;

    always_comb
    begin
        state_next    = state_reg;
        acnt_next     = acnt_reg;
        vcnt_next     = vcnt_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        chk_idx_next  = idx_reg;
        a_chk_next    = a_issue;
        v_chk_next    = v_issue;
        a_hit_next    = a_hit_reg;
        v_hit_next    = v_hit_reg;
        rec_id_next   = rec_id_reg;
        rec_rate_next = rec_rate_reg;
        amin_next     = amin_reg;
        b1_found_next = b1_found_reg;
        b1_rate_next  = b1_rate_reg;
        b1_id_next    = b1_id_reg;
        b2_found_next = b2_found_reg;
        b2_rate_next  = b2_rate_reg;
        b2_id_next    = b2_id_reg;
        ba_found_next = ba_found_reg;
        ba_rate_next  = ba_rate_reg;
        ba_id_next    = ba_id_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        a_req         = '0;
        v_req         = '0;
        a_req.raddr   = idx_reg[IDX_W-1:0];
        v_req.raddr   = idx_reg[IDX_W-1:0];

        // Advance the read pointer while either table has entries left
        if (a_issue || v_issue)
        begin
            idx_next = idx_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        MODE_DECL:
                        begin
                            // Append a declaration with its rate cleared
                            if (cmd.type_prefix == AUDIO_PREFIX)
                            begin
                                if (acnt_reg < CNT_W'(MAX_STREAMS))
                                begin
                                    a_req.we         = 1'b1;
                                    a_req.waddr      = acnt_reg[IDX_W-1:0];
                                    a_req.wdata.id   = cmd.stream_num;
                                    a_req.wdata.rate = '0;
                                    acnt_next        = acnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            else if (cmd.type_prefix == VIDEO_PREFIX)
                            begin
                                if (vcnt_reg < CNT_W'(MAX_STREAMS))
                                begin
                                    v_req.we         = 1'b1;
                                    v_req.waddr      = vcnt_reg[IDX_W-1:0];
                                    v_req.wdata.id   = cmd.stream_num;
                                    v_req.wdata.rate = '0;
                                    vcnt_next        = vcnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        MODE_RATE:
                        begin
                            rec_id_next   = cmd.stream_num;
                            rec_rate_next = cmd.rate;
                            a_hit_next    = 1'b0;
                            v_hit_next    = 1'b0;
                            idx_next      = '0;
                            state_next    = ST_REC;
                        end
                        MODE_SELECT:
                        begin
                            amin_next     = '0;
                            b1_found_next = 1'b0;
                            b1_rate_next  = '0;
                            b1_id_next    = '0;
                            b2_found_next = 1'b0;
                            b2_rate_next  = '0;
                            b2_id_next    = '0;
                            ba_found_next = 1'b0;
                            ba_rate_next  = '0;
                            ba_id_next    = '0;
                            idx_next      = '0;
                            state_next    = ST_AMIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_REC:
            begin
                // Write the rate back into the first matching entry of each table
                if (a_chk_reg && !a_hit_reg && (a_rdata.id == rec_id_reg))
                begin
                    a_req.we         = 1'b1;
                    a_req.waddr      = chk_idx_reg[IDX_W-1:0];
                    a_req.wdata.id   = rec_id_reg;
                    a_req.wdata.rate = rec_rate_reg;
                    a_hit_next       = 1'b1;
                end
                if (v_chk_reg && !v_hit_reg && (v_rdata.id == rec_id_reg))
                begin
                    v_req.we         = 1'b1;
                    v_req.waddr      = chk_idx_reg[IDX_W-1:0];
                    v_req.wdata.id   = rec_id_reg;
                    v_req.wdata.rate = rec_rate_reg;
                    v_hit_next       = 1'b1;
                end
                if (scan_done)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_AMIN:
            begin
                // Track the lowest audio rate
                if (a_chk_reg && ((chk_idx_reg == '0) || (a_rdata.rate < amin_reg)))
                begin
                    amin_next = a_rdata.rate;
                end
                if (scan_done)
                begin
                    idx_next   = '0;
                    state_next = ST_VID;
                end
            end

            ST_VID:
            begin
                // Best video fit with and without the lowest audio rate
                if (v_chk_reg)
                begin
                    if (fits1 && (!b1_found_reg || (v_rdata.rate > b1_rate_reg)))
                    begin
                        b1_found_next = 1'b1;
                        b1_rate_next  = v_rdata.rate;
                        b1_id_next    = v_rdata.id;
                    end
                    if (fits2 && (!b2_found_reg || (v_rdata.rate > b2_rate_reg)))
                    begin
                        b2_found_next = 1'b1;
                        b2_rate_next  = v_rdata.rate;
                        b2_id_next    = v_rdata.id;
                    end
                end
                if (scan_done)
                begin
                    idx_next   = '0;
                    state_next = ST_AUD;
                end
            end

            ST_AUD:
            begin
                // Best audio fit next to the chosen video
                if (a_chk_reg && fits_a && (!ba_found_reg || (a_rdata.rate > ba_rate_reg)))
                begin
                    ba_found_next = 1'b1;
                    ba_rate_next  = a_rdata.rate;
                    ba_id_next    = a_rdata.id;
                end
                if (scan_done)
                begin
                    result_next.audio_found    = ba_found_reg;
                    result_next.audio_choice   = ba_id_reg;
                    result_next.video_found    = v_found;
                    result_next.video_choice   = v_id;
                    result_next.none_fit       = !ba_found_reg && !v_found;
                    result_next.table_overflow = ovf_reg;
                    done_next                  = 1'b1;
                    acnt_next                  = '0;
                    vcnt_next                  = '0;
                    ovf_next                   = 1'b0;
                    idx_next                   = '0;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            acnt_reg     <= '0;
            vcnt_reg     <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            chk_idx_reg  <= '0;
            a_chk_reg    <= 1'b0;
            v_chk_reg    <= 1'b0;
            a_hit_reg    <= 1'b0;
            v_hit_reg    <= 1'b0;
            rec_id_reg   <= '0;
            rec_rate_reg <= '0;
            amin_reg     <= '0;
            b1_found_reg <= 1'b0;
            b1_rate_reg  <= '0;
            b1_id_reg    <= '0;
            b2_found_reg <= 1'b0;
            b2_rate_reg  <= '0;
            b2_id_reg    <= '0;
            ba_found_reg <= 1'b0;
            ba_rate_reg  <= '0;
            ba_id_reg    <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            acnt_reg     <= acnt_next;
            vcnt_reg     <= vcnt_next;
            ovf_reg      <= ovf_next;
            idx_reg      <= idx_next;
            chk_idx_reg  <= chk_idx_next;
            a_chk_reg    <= a_chk_next;
            v_chk_reg    <= v_chk_next;
            a_hit_reg    <= a_hit_next;
            v_hit_reg    <= v_hit_next;
            rec_id_reg   <= rec_id_next;
            rec_rate_reg <= rec_rate_next;
            amin_reg     <= amin_next;
            b1_found_reg <= b1_found_next;
            b1_rate_reg  <= b1_rate_next;
            b1_id_reg    <= b1_id_next;
            b2_found_reg <= b2_found_next;
            b2_rate_reg  <= b2_rate_next;
            b2_id_reg    <= b2_id_next;
            ba_found_reg <= ba_found_next;
            ba_rate_reg  <= ba_rate_next;
            ba_id_reg    <= ba_id_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    // Table fill never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        (acnt_reg <= CNT_W'(MAX_STREAMS)) && (vcnt_reg <= CNT_W'(MAX_STREAMS)))
        else $error("stream count beyond table size");

    // A checked entry always lies below the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_chk_reg |-> (chk_idx_reg < acnt_reg))
        and (v_chk_reg |-> (chk_idx_reg < vcnt_reg)))
        else $error("table read past fill count");

    // Tables are written only on declarations and rate records
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_req.we || v_req.we) |-> ((state_reg == ST_IDLE) || (state_reg == ST_REC)))
        else $error("table write during selection");

    // The result beat finds the tables emptied and the block free
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((acnt_reg == '0) && (vcnt_reg == '0) && !ovf_reg && !busy))
        else $error("tables not cleared after select");

    // The result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import bsps_pkg::*;

    // Mode 3 is not decoded by the block
    localparam logic [1:0] MODE_NONE = 2'd3;
    // Longest busy stretch of a command: a select over two full tables
    localparam int SETTLE_CYCLES = 60;
    localparam logic [RATE_W-1:0] FULL_BUDGET = '1;

    typedef enum logic [1:0] {ACT_SEND, ACT_WRITE_BW, ACT_PAUSE, ACT_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t        kind;
        cmd_t              item;
        logic [RATE_W-1:0] bw;
        int                cycles;
    } step_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    cmd_t              cmd = '0;
    logic              done;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data = '0;

    bandwidth_stream_pair_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the stream tables and the budget register
    logic [ID_W-1:0]   aud_id   [MAX_STREAMS];
    logic [RATE_W-1:0] aud_rate [MAX_STREAMS];
    logic [ID_W-1:0]   vid_id   [MAX_STREAMS];
    logic [RATE_W-1:0] vid_rate [MAX_STREAMS];
    int                aud_n;
    int                vid_n;
    bit                dropped;
    logic [RATE_W-1:0] budget;

    step_t   cmd_plan[$];
    result_t pending_picks[$];

    int      n_planned;
    int      n_sent;
    int      n_bw;
    int      n_checked;
    int      n_spill;
    int      n_nofit;
    int      n_fail;
    bit      gappy;
    bit      plan_done;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Empty both tables, as a select does
    function automatic void clear_tables();
        for (int i = 0; i < MAX_STREAMS; i++)
        begin
            aud_rate[i] = '0;
            vid_rate[i] = '0;
        end
        aud_n   = 0;
        vid_n   = 0;
        dropped = 1'b0;
    endfunction

    // Highest rate not above bound, earliest on ties; -1 when nothing fits
    function automatic int best_under(input bit video, input longint bound);
        int     n;
        int     best;
        longint top;
        longint r;
        n    = video ? vid_n : aud_n;
        best = -1;
        top  = -1;
        for (int i = 0; i < n; i++)
        begin
            r = video ? longint'(vid_rate[i]) : longint'(aud_rate[i]);
            if (r > top && r <= bound)
            begin
                top  = r;
                best = i;
            end
        end
        return best;
    endfunction

    // Advance the shadow tables by one accepted command
    function automatic void model_command(input cmd_t c);
        result_t pick;
        longint  bw;
        longint  a_low;
        longint  v_rate;
        int      a_idx;
        int      v_idx;
        bit      hit;
        case (c.mode)
            MODE_DECL:
            begin
                if (c.type_prefix == AUDIO_PREFIX)
                begin
                    if (aud_n < MAX_STREAMS)
                    begin
                        aud_id[aud_n]   = c.stream_num;
                        aud_rate[aud_n] = '0;
                        aud_n++;
                    end
                    else
                        dropped = 1'b1;
                end
                else if (c.type_prefix == VIDEO_PREFIX)
                begin
                    if (vid_n < MAX_STREAMS)
                    begin
                        vid_id[vid_n]   = c.stream_num;
                        vid_rate[vid_n] = '0;
                        vid_n++;
                    end
                    else
                        dropped = 1'b1;
                end
            end
            MODE_RATE:
            begin
                // First matching entry of each table takes the rate
                hit = 1'b0;
                for (int j = 0; j < aud_n && !hit; j++)
                    if (aud_id[j] == c.stream_num)
                    begin
                        aud_rate[j] = c.rate;
                        hit = 1'b1;
                    end
                hit = 1'b0;
                for (int j = 0; j < vid_n && !hit; j++)
                    if (vid_id[j] == c.stream_num)
                    begin
                        vid_rate[j] = c.rate;
                        hit = 1'b1;
                    end
            end
            MODE_SELECT:
            begin
                bw     = (budget == 0) ? longint'(FULL_BUDGET) : longint'(budget);
                a_low  = 0;
                v_rate = 0;
                // Reserve the cheapest audio rate unless it starves video
                if (aud_n > 0)
                begin
                    a_low = longint'(aud_rate[0]);
                    for (int i = 1; i < aud_n; i++)
                        if (longint'(aud_rate[i]) < a_low)
                            a_low = longint'(aud_rate[i]);
                    if (best_under(1'b1, bw - a_low) < 0)
                        a_low = 0;
                end
                v_idx = best_under(1'b1, bw - a_low);
                if (v_idx >= 0)
                    v_rate = longint'(vid_rate[v_idx]);
                a_idx = best_under(1'b0, bw - v_rate);
                pick = '0;
                if (a_idx >= 0)
                begin
                    pick.audio_found  = 1'b1;
                    pick.audio_choice = aud_id[a_idx];
                end
                if (v_idx >= 0)
                begin
                    pick.video_found  = 1'b1;
                    pick.video_choice = vid_id[v_idx];
                end
                pick.none_fit       = (a_idx < 0) && (v_idx < 0);
                pick.table_overflow = dropped;
                pending_picks.push_back(pick);
                clear_tables();
            end
            default: ;
        endcase
    endfunction

    // Command and budget driver, fed from cmd_plan
    int    idle_left;
    int    settle_left;
    bit    draining;
    bit    start_nx;
    bit    cfg_nx;
    step_t act;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            cmd         <= '0;
            cfg_valid   <= 1'b0;
            cfg_data    <= '0;
            idle_left   = 0;
            settle_left = 0;
            draining    = 1'b0;
            budget      = '0;
            clear_tables();
        end
        else
        begin
            // Retire the beats taken at this edge
            if (start && !busy)
            begin
                model_command(cmd);
                n_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                budget = cfg_data;
                n_bw++;
            end
            // Hold a beat that is still waiting, otherwise advance the plan
            if (!((start && busy) || (cfg_valid && !cfg_ready)))
            begin
                start_nx = 1'b0;
                cfg_nx   = 1'b0;
                if (idle_left > 0)
                    idle_left--;
                else if (draining)
                begin
                    if (pending_picks.size() == 0)
                    begin
                        if (settle_left > 0)
                            settle_left--;
                        else
                            draining = 1'b0;
                    end
                end
                else if (cmd_plan.size() > 0)
                begin
                    act = cmd_plan.pop_front();
                    case (act.kind)
                        ACT_SEND:
                        begin
                            start_nx = 1'b1;
                            cmd <= act.item;
                        end
                        ACT_WRITE_BW:
                        begin
                            cfg_nx = 1'b1;
                            cfg_data <= act.bw;
                        end
                        ACT_PAUSE:
                            idle_left = act.cycles - 1;
                        default:
                        begin
                            draining    = 1'b1;
                            settle_left = act.cycles;
                        end
                    endcase
                end
                else
                    plan_done = 1'b1;
                start     <= start_nx;
                cfg_valid <= cfg_nx;
            end
        end
    end

    // Result monitor: compare each beat with the oldest prediction
    result_t want;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("tb: unexpected result at %0t: audio %b/%h video %b/%h none %b ovf %b",
                             $realtime, result.audio_found, result.audio_choice,
                             result.video_found, result.video_choice, result.none_fit,
                             result.table_overflow);
            end
            else
            begin
                want = pending_picks.pop_front();
                n_checked++;
                if (want.table_overflow)
                    n_spill++;
                if (want.none_fit)
                    n_nofit++;
                if (result.audio_found !== want.audio_found
                    || result.audio_choice !== want.audio_choice
                    || result.video_found !== want.video_found
                    || result.video_choice !== want.video_choice
                    || result.none_fit !== want.none_fit
                    || result.table_overflow !== want.table_overflow)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("tb: mismatch at %0t: got audio %b/%h video %b/%h none %b ovf %b, %s",
                                 $realtime, result.audio_found, result.audio_choice,
                                 result.video_found, result.video_choice, result.none_fit,
                                 result.table_overflow,
                                 $sformatf("want audio %b/%h video %b/%h none %b ovf %b",
                                           want.audio_found, want.audio_choice,
                                           want.video_found, want.video_choice,
                                           want.none_fit, want.table_overflow));
                end
            end
        end
    end

    task automatic add_pause(input int n);
        step_t s;
        s = '{kind: ACT_PAUSE, item: '0, bw: '0, cycles: n};
        cmd_plan.push_back(s);
    endtask

    // Wait for every result plus the settle time, then write the budget
    task automatic write_budget(input logic [RATE_W-1:0] bw);
        step_t s;
        s = '{kind: ACT_DRAIN, item: '0, bw: '0, cycles: SETTLE_CYCLES};
        cmd_plan.push_back(s);
        s.kind   = ACT_WRITE_BW;
        s.bw     = bw;
        cmd_plan.push_back(s);
    endtask

    task automatic send(input logic [1:0] mode, input logic [PREFIX_W-1:0] prefix,
                        input logic [ID_W-1:0] id, input logic [RATE_W-1:0] rate);
        step_t s;
        if (gappy && $urandom % 4 == 0)
            add_pause(($urandom % 10 == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3));
        s                  = '{kind: ACT_SEND, item: '0, bw: '0, cycles: 0};
        s.item.mode        = mode;
        s.item.type_prefix = prefix;
        s.item.stream_num  = id;
        s.item.rate        = rate;
        cmd_plan.push_back(s);
        n_planned++;
    endtask

    // Rates cluster around the budget so that the fit decisions are close
    function automatic logic [RATE_W-1:0] draw_rate(input logic [RATE_W-1:0] bw);
        logic [RATE_W-1:0] span;
        span = (bw == 0) ? FULL_BUDGET : bw;
        case ($urandom % 7)
            0:       return '0;
            1:       return RATE_W'($urandom);
            2:       return RATE_W'($urandom_range(0, span));
            3:       return span - RATE_W'($urandom_range(0, 3));
            4:       return FULL_BUDGET;
            5:       return RATE_W'($urandom_range(0, 1000));
            default: return RATE_W'($urandom_range(span / 2, span));
        endcase
    endfunction

    function automatic logic [PREFIX_W-1:0] draw_prefix();
        int r;
        r = $urandom % 20;
        if (r < 9)
            return AUDIO_PREFIX;
        if (r < 18)
            return VIDEO_PREFIX;
        if (r == 18)
            return AUDIO_PREFIX ^ (32'd1 << ($urandom % 32));
        return $urandom;
    endfunction

    logic [RATE_W-1:0] bw_pick;
    logic [ID_W-1:0]   base;
    int                n_decl;
    int                n_rec;

    initial
    begin
        // Directed: unlimited budget, unreported rate, ignored prefixes, mode 3,
        // unmatched record, then a select and a second select on the emptied tables
        gappy = 1'b0;
        write_budget('0);
        send(MODE_DECL, AUDIO_PREFIX, 16'h0000, '0);
        send(MODE_DECL, VIDEO_PREFIX, 16'hffff, FULL_BUDGET);
        send(MODE_DECL, 32'h0000_0000, 16'h1111, '0);
        send(MODE_DECL, 32'hffff_ffff, 16'h2222, '0);
        send(MODE_NONE, 32'hffff_ffff, 16'hffff, FULL_BUDGET);
        send(MODE_RATE, '0, 16'hffff, FULL_BUDGET);
        send(MODE_RATE, '0, 16'h4321, 31'd5);
        send(MODE_SELECT, '0, '0, '0);
        send(MODE_SELECT, 32'hffff_ffff, 16'hffff, FULL_BUDGET);
        // Smallest budget: nothing fits, then a pair that just fits together
        write_budget(31'd1);
        send(MODE_DECL, AUDIO_PREFIX, 16'd7, '0);
        send(MODE_DECL, VIDEO_PREFIX, 16'd7, '0);
        send(MODE_RATE, '0, 16'd7, 31'd2);
        send(MODE_SELECT, '0, '0, '0);
        send(MODE_DECL, AUDIO_PREFIX, 16'd9, '0);
        send(MODE_DECL, VIDEO_PREFIX, 16'd9, '0);
        send(MODE_DECL, VIDEO_PREFIX, 16'd10, '0);
        send(MODE_RATE, '0, 16'd10, 31'd1);
        send(MODE_SELECT, '0, '0, '0);
        // Largest budget: ties go to the earliest entry, duplicate ids
        write_budget(FULL_BUDGET);
        send(MODE_DECL, AUDIO_PREFIX, 16'd3, '0);
        send(MODE_DECL, AUDIO_PREFIX, 16'd4, '0);
        send(MODE_DECL, VIDEO_PREFIX, 16'd5, '0);
        send(MODE_DECL, VIDEO_PREFIX, 16'd5, '0);
        send(MODE_RATE, '0, 16'd5, 31'h4000_0000);
        send(MODE_SELECT, '0, '0, '0);

        // Random phases: one budget each, several declaration sets per phase
        while (n_planned < 850)
        begin
            case ($urandom % 6)
                0:       bw_pick = '0;
                1:       bw_pick = FULL_BUDGET;
                2:       bw_pick = RATE_W'($urandom_range(1, 50));
                3:       bw_pick = RATE_W'($urandom_range(1, 3000));
                default: bw_pick = RATE_W'($urandom);
            endcase
            write_budget(bw_pick);
            gappy = ($urandom % 3 != 0);
            repeat ($urandom_range(2, 6))
            begin
                base   = ID_W'($urandom);
                n_decl = ($urandom % 8 == 0) ? $urandom_range(18, 40) : $urandom_range(0, 9);
                n_rec  = $urandom_range(0, n_decl + 2);
                repeat (n_decl)
                begin
                    send(MODE_DECL, draw_prefix(),
                         ($urandom % 10 == 0) ? ID_W'($urandom) : base ^ ID_W'($urandom_range(0, 7)),
                         RATE_W'($urandom));
                    // Out of order: a record ahead of its declaration
                    if ($urandom % 10 == 0)
                        send(MODE_RATE, $urandom, base ^ ID_W'($urandom_range(0, 7)),
                             draw_rate(bw_pick));
                    if ($urandom % 25 == 0)
                        send(MODE_NONE, $urandom, ID_W'($urandom), RATE_W'($urandom));
                end
                repeat (n_rec)
                    send(MODE_RATE, $urandom,
                         ($urandom % 6 == 0) ? ID_W'($urandom) : base ^ ID_W'($urandom_range(0, 7)),
                         draw_rate(bw_pick));
                send(MODE_SELECT, $urandom, ID_W'($urandom), RATE_W'($urandom));
                if ($urandom % 8 == 0)
                    send(MODE_SELECT, $urandom, ID_W'($urandom), RATE_W'($urandom));
            end
        end
        cmd_plan.push_back('{kind: ACT_DRAIN, item: '0, bw: '0, cycles: SETTLE_CYCLES});

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (plan_done);
        $display("tb: %0d commands sent, %0d budget writes, %0d selections checked",
                 n_sent, n_bw, n_checked);
        $display("tb: %0d selections reported dropped declarations, %0d found nothing to fit",
                 n_spill, n_nofit);
        if (n_fail == 0)
            $display("tb: PASS");
        else
        begin
            $display("tb: %0d mismatches", n_fail);
            $display("tb: FAIL");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: timeout with %0d results outstanding", pending_picks.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule
